/* src/qrm_pkg.sv */
// Shared types, widths and rounding helpers for the quaternion to matrix pipeline.
`default_nettype none

package qrm_pkg;

    localparam int QW = 16;     // Q2.14 component / rotation entry width
    localparam int CW = 32;     // Q16.16 coordinate width
    localparam int PW = 2 * QW; // quaternion component product
    localparam int SW = PW + 2; // signed sum of four products, or doubled pair
    localparam int TW = CW + QW;  // coordinate times rotation entry
    localparam int AW = TW + 1;   // translation accumulator
    localparam int FRAC = 14;

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic signed [CW-1:0] centre_z;
    } t_quat_in;

    typedef struct packed {
        logic signed [QW-1:0] rot_00;
        logic signed [QW-1:0] rot_01;
        logic signed [QW-1:0] rot_02;
        logic signed [CW-1:0] trans_x;
        logic signed [QW-1:0] rot_10;
        logic signed [QW-1:0] rot_11;
        logic signed [QW-1:0] rot_12;
        logic signed [CW-1:0] trans_y;
        logic signed [QW-1:0] rot_20;
        logic signed [QW-1:0] rot_21;
        logic signed [QW-1:0] rot_22;
        logic signed [CW-1:0] trans_z;
    } t_mat_out;

    // rotation entries plus the centre, handed from the rotation half to the translation half
    typedef struct packed {
        logic signed [QW-1:0] rot_00;
        logic signed [QW-1:0] rot_01;
        logic signed [QW-1:0] rot_02;
        logic signed [QW-1:0] rot_10;
        logic signed [QW-1:0] rot_11;
        logic signed [QW-1:0] rot_12;
        logic signed [QW-1:0] rot_20;
        logic signed [QW-1:0] rot_21;
        logic signed [QW-1:0] rot_22;
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic signed [CW-1:0] centre_z;
    } t_rot_set;

    // add half an LSB, floor, saturate to Q2.14
    function automatic logic signed [QW-1:0] rnd_sat16(input logic signed [SW-1:0] v);
        logic signed [SW:0]        t;
        logic signed [SW-FRAC:0]   s;
        t = (SW+1)'(v) + (SW+1)'(1 << (FRAC - 1));
        s = (SW-FRAC+1)'(t >>> FRAC);
        if (s > (SW-FRAC+1)'(32767))
            return 16'sh7fff;
        else if (s < -(SW-FRAC+1)'(32768))
            return 16'sh8000;
        else
            return s[QW-1:0];
    endfunction

    // add half an LSB, floor, saturate to Q16.16
    function automatic logic signed [CW-1:0] rnd_sat32(input logic signed [AW-1:0] v);
        logic signed [AW:0]        t;
        logic signed [AW-FRAC:0]   s;
        t = (AW+1)'(v) + (AW+1)'(1 << (FRAC - 1));
        s = (AW-FRAC+1)'(t >>> FRAC);
        if (s > (AW-FRAC+1)'(64'sh7fffffff))
            return 32'sh7fffffff;
        else if (s < -(AW-FRAC+1)'(64'sh80000000))
            return 32'sh80000000;
        else
            return s[CW-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/quaternion_to_rotation_matrix.sv */
// Top level: quaternion plus centre in, 3x4 affine rotation-about-point matrix out.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_stall   t_quat_in (quaternion Q2.14, centre Q16.16)
//   out      output     o_out_valid / i_out_stall t_mat_out (rotation Q2.14, translation Q16.16)
//
// Four register stages: component products, rotation entries, centre-by-row
// products, translations. One word per cycle sustained while i_out_stall stays low.
// Synchronous active-low reset clears the stage valid bits only.
// A stall holds only the stages that are full; empty stages keep filling, and
// o_in_stall rises only when every stage holds a word.
`default_nettype none

module quaternion_to_rotation_matrix import qrm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_quat_in i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_mat_out      o_out_data
);

    logic     rot_valid;
    logic     rot_stall;
    t_rot_set rot_set;

    qrm_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_quat  (i_in_data),
        .o_valid (rot_valid),
        .i_stall (rot_stall),
        .o_rot   (rot_set)
    );

    qrm_trans u_trans (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rot_valid),
        .o_stall (rot_stall),
        .i_rot   (rot_set),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_mat   (o_out_data)
    );

endmodule

`default_nettype wire

/* src/qrm_rot.sv */
// Stages 1-2: quaternion component products, then rounded and saturated rotation entries.
`default_nettype none

module qrm_rot import qrm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_quat_in i_quat,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_rot_set      o_rot
);

    typedef struct packed {
        logic signed [PW-1:0] ww, xx, yy, zz;
        logic signed [PW-1:0] xy, zw, xz, yw, yz, xw;
    } t_prod;

    logic                 r_v1, r_v2;
    t_prod                r_prod, n_prod;
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    t_rot_set             r_rot, n_rot;
    logic                 stall1, stall2;

    assign stall2  = r_v2 & i_stall;
    assign stall1  = r_v1 & stall2;
    assign o_stall = stall1;
    assign o_valid = r_v2;
    assign o_rot   = r_rot;

    always_comb begin
        n_prod.ww = i_quat.quat_w * i_quat.quat_w;
        n_prod.xx = i_quat.quat_x * i_quat.quat_x;
        n_prod.yy = i_quat.quat_y * i_quat.quat_y;
        n_prod.zz = i_quat.quat_z * i_quat.quat_z;
        n_prod.xy = i_quat.quat_x * i_quat.quat_y;
        n_prod.zw = i_quat.quat_z * i_quat.quat_w;
        n_prod.xz = i_quat.quat_x * i_quat.quat_z;
        n_prod.yw = i_quat.quat_y * i_quat.quat_w;
        n_prod.yz = i_quat.quat_y * i_quat.quat_z;
        n_prod.xw = i_quat.quat_x * i_quat.quat_w;
    end

    always_comb begin
        n_rot.rot_00 = rnd_sat16(SW'(r_prod.xx) - SW'(r_prod.yy) - SW'(r_prod.zz)
                                 + SW'(r_prod.ww));
        n_rot.rot_11 = rnd_sat16(SW'(r_prod.yy) - SW'(r_prod.xx) - SW'(r_prod.zz)
                                 + SW'(r_prod.ww));
        n_rot.rot_22 = rnd_sat16(SW'(r_prod.zz) - SW'(r_prod.xx) - SW'(r_prod.yy)
                                 + SW'(r_prod.ww));
        n_rot.rot_10 = rnd_sat16((SW'(r_prod.xy) + SW'(r_prod.zw)) <<< 1);
        n_rot.rot_01 = rnd_sat16((SW'(r_prod.xy) - SW'(r_prod.zw)) <<< 1);
        n_rot.rot_20 = rnd_sat16((SW'(r_prod.xz) - SW'(r_prod.yw)) <<< 1);
        n_rot.rot_02 = rnd_sat16((SW'(r_prod.xz) + SW'(r_prod.yw)) <<< 1);
        n_rot.rot_21 = rnd_sat16((SW'(r_prod.yz) + SW'(r_prod.xw)) <<< 1);
        n_rot.rot_12 = rnd_sat16((SW'(r_prod.yz) - SW'(r_prod.xw)) <<< 1);
        n_rot.centre_x = r_cx;
        n_rot.centre_y = r_cy;
        n_rot.centre_z = r_cz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (!stall1)
                r_v1 <= i_valid;
            if (!stall2)
                r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall1) begin
            r_prod <= n_prod;
            r_cx   <= i_quat.centre_x;
            r_cy   <= i_quat.centre_y;
            r_cz   <= i_quat.centre_z;
        end
        if (!stall2)
            r_rot <= n_rot;
    end

endmodule

`default_nettype wire

/* src/qrm_trans.sv */
// Stages 3-4: centre times rotation rows, then rounded and saturated translations.
`default_nettype none

module qrm_trans import qrm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_rot_set i_rot,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_mat_out      o_mat
);

    typedef struct packed {
        logic signed [TW-1:0] p00, p01, p02;
        logic signed [TW-1:0] p10, p11, p12;
        logic signed [TW-1:0] p20, p21, p22;
    } t_tprod;

    logic     r_v3, r_v4;
    t_tprod   r_tp, n_tp;
    t_rot_set r_rot;
    t_mat_out r_mat, n_mat;
    logic     stall3, stall4;

    assign stall4  = r_v4 & i_stall;
    assign stall3  = r_v3 & stall4;
    assign o_stall = stall3;
    assign o_valid = r_v4;
    assign o_mat   = r_mat;

    // row r of the rotation against the centre vector
    always_comb begin
        n_tp.p00 = i_rot.centre_x * i_rot.rot_00;
        n_tp.p01 = i_rot.centre_y * i_rot.rot_01;
        n_tp.p02 = i_rot.centre_z * i_rot.rot_02;
        n_tp.p10 = i_rot.centre_x * i_rot.rot_10;
        n_tp.p11 = i_rot.centre_y * i_rot.rot_11;
        n_tp.p12 = i_rot.centre_z * i_rot.rot_12;
        n_tp.p20 = i_rot.centre_x * i_rot.rot_20;
        n_tp.p21 = i_rot.centre_y * i_rot.rot_21;
        n_tp.p22 = i_rot.centre_z * i_rot.rot_22;
    end

    always_comb begin
        n_mat.rot_00  = r_rot.rot_00;
        n_mat.rot_01  = r_rot.rot_01;
        n_mat.rot_02  = r_rot.rot_02;
        n_mat.rot_10  = r_rot.rot_10;
        n_mat.rot_11  = r_rot.rot_11;
        n_mat.rot_12  = r_rot.rot_12;
        n_mat.rot_20  = r_rot.rot_20;
        n_mat.rot_21  = r_rot.rot_21;
        n_mat.rot_22  = r_rot.rot_22;
        n_mat.trans_x = rnd_sat32((AW'(r_rot.centre_x) <<< FRAC) - AW'(r_tp.p00)
                                  - AW'(r_tp.p01) - AW'(r_tp.p02));
        n_mat.trans_y = rnd_sat32((AW'(r_rot.centre_y) <<< FRAC) - AW'(r_tp.p10)
                                  - AW'(r_tp.p11) - AW'(r_tp.p12));
        n_mat.trans_z = rnd_sat32((AW'(r_rot.centre_z) <<< FRAC) - AW'(r_tp.p20)
                                  - AW'(r_tp.p21) - AW'(r_tp.p22));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (!stall3)
                r_v3 <= i_valid;
            if (!stall4)
                r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall3) begin
            r_tp  <= n_tp;
            r_rot <= i_rot;
        end
        if (!stall4)
            r_mat <= n_mat;
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the quaternion to rotation-about-point matrix block.
`timescale 1ns / 1ps

module tb_top;
    import qrm_pkg::*;

    localparam int     CMIN       = 32'sh8000_0000;
    localparam int     CMAX       = 32'sh7fff_ffff;
    localparam longint T_MIN      = -64'sd2147483648;
    localparam longint T_MAX      = 64'sd2147483647;
    localparam int     IDLE_LIMIT = 1000;
    localparam int     LONG_HOLD  = 90;
    localparam int     CHUNKS     = 4;
    localparam int     CHUNK_LEN  = 250;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_quat_in in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_mat_out out_data;

    logic     in_fire   = 1'b0;
    logic     out_fire  = 1'b0;

    t_quat_in pose_queue[$];
    t_mat_out matrix_due[$];

    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int popped       = 0;
    int send_gap     = 0;
    int rx_wait      = 0;
    int long_holds   = 0;
    int held_cycles  = 0;
    int idle_cycles  = 0;

    quaternion_to_rotation_matrix dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // add half an LSB, floor
    function automatic longint round14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint rot_q14(longint v);
        return clamp(round14(v), -64'sd32768, 64'sd32767);
    endfunction

    function automatic t_mat_out rotate_about_centre(t_quat_in p);
        longint w, x, y, z, cx, cy, cz;
        longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint tx, ty, tz;
        t_mat_out m;
        w  = $signed(p.quat_w);
        x  = $signed(p.quat_x);
        y  = $signed(p.quat_y);
        z  = $signed(p.quat_z);
        cx = $signed(p.centre_x);
        cy = $signed(p.centre_y);
        cz = $signed(p.centre_z);

        r00 = rot_q14(x * x - y * y - z * z + w * w);
        r11 = rot_q14(-x * x + y * y - z * z + w * w);
        r22 = rot_q14(-x * x - y * y + z * z + w * w);
        r10 = rot_q14(2 * (x * y + z * w));
        r01 = rot_q14(2 * (x * y - z * w));
        r20 = rot_q14(2 * (x * z - y * w));
        r02 = rot_q14(2 * (x * z + y * w));
        r21 = rot_q14(2 * (y * z + x * w));
        r12 = rot_q14(2 * (y * z - x * w));

        m.rot_00  = r00[15:0];
        m.rot_01  = r01[15:0];
        m.rot_02  = r02[15:0];
        m.rot_10  = r10[15:0];
        m.rot_11  = r11[15:0];
        m.rot_12  = r12[15:0];
        m.rot_20  = r20[15:0];
        m.rot_21  = r21[15:0];
        m.rot_22  = r22[15:0];
        // translations use the already saturated rotation entries
        tx = clamp(round14(cx * 16384 - cx * r00 - cy * r01 - cz * r02), T_MIN, T_MAX);
        ty = clamp(round14(cy * 16384 - cx * r10 - cy * r11 - cz * r12), T_MIN, T_MAX);
        tz = clamp(round14(cz * 16384 - cx * r20 - cy * r21 - cz * r22), T_MIN, T_MAX);
        m.trans_x = tx[31:0];
        m.trans_y = ty[31:0];
        m.trans_z = tz[31:0];
        return m;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // every fourth stretch of 40 words runs with no idling
    function automatic int idle_draw(int count);
        if ((count / 40) % 4 == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic int random_q14();
        unique case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int random_coord();
        unique case ($urandom_range(0, 9))
            0:          return CMIN;
            1:          return CMAX;
            2:          return 0;
            3, 4, 5:    return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            default:    return int'($urandom);
        endcase
    endfunction

    function automatic void queue_pose(int w, int x, int y, int z, int cx, int cy, int cz);
        t_quat_in p;
        p.quat_w   = w[15:0];
        p.quat_x   = x[15:0];
        p.quat_y   = y[15:0];
        p.quat_z   = z[15:0];
        p.centre_x = cx;
        p.centre_y = cy;
        p.centre_z = cz;
        pose_queue.push_back(p);
    endfunction

    // driver: next word goes out at the falling edge once the last one was taken
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pose_queue.size() > 0) begin
                in_data  <= pose_queue.pop_front();
                in_valid <= 1'b1;
                send_gap <= idle_draw(popped);
                popped++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall; one long hold-off partway through so the pipe backs up
    always @(negedge clk) begin : receiver
        int left;
        left = rx_wait;
        if (out_fire) begin
            left = idle_draw(results_seen);
            if (results_seen == 300) begin
                left = LONG_HOLD;
                long_holds++;
            end
        end else if (left > 0) begin
            left--;
        end
        rx_wait = left;
        out_stall <= (left != 0);
    end

    // monitor and scoreboard
    always @(posedge clk) begin : monitor
        t_mat_out due;
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (matrix_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    due = matrix_due.pop_front();
                    check_field("rot_00",  $signed(due.rot_00),  $signed(out_data.rot_00));
                    check_field("rot_01",  $signed(due.rot_01),  $signed(out_data.rot_01));
                    check_field("rot_02",  $signed(due.rot_02),  $signed(out_data.rot_02));
                    check_field("trans_x", $signed(due.trans_x), $signed(out_data.trans_x));
                    check_field("rot_10",  $signed(due.rot_10),  $signed(out_data.rot_10));
                    check_field("rot_11",  $signed(due.rot_11),  $signed(out_data.rot_11));
                    check_field("rot_12",  $signed(due.rot_12),  $signed(out_data.rot_12));
                    check_field("trans_y", $signed(due.trans_y), $signed(out_data.trans_y));
                    check_field("rot_20",  $signed(due.rot_20),  $signed(out_data.rot_20));
                    check_field("rot_21",  $signed(due.rot_21),  $signed(out_data.rot_21));
                    check_field("rot_22",  $signed(due.rot_22),  $signed(out_data.rot_22));
                    check_field("trans_z", $signed(due.trans_z), $signed(out_data.trans_z));
                end
            end
            if (in_valid && !in_stall) begin
                matrix_due.push_back(rotate_about_centre(in_data));
                items_sent++;
            end
            if (in_valid && in_stall)
                held_cycles++;

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no word moved for %0d cycles", IDLE_LIMIT);
                $display("quaternion_to_rotation_matrix: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        real a, b, c, d, norm;
        int  chunk, k;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed poses
        queue_pose(0, 0, 0, 0, 0, 0, 0);
        queue_pose(16384, 0, 0, 0, 0, 0, 0);
        queue_pose(16384, 0, 0, 0, 98304, -131072, 196608);
        queue_pose(11585, 0, 0, 11585, 65536, 0, 0);            // quarter turn about z
        queue_pose(11585, 11585, 0, 0, 0, 65536, -65536);       // quarter turn about x
        queue_pose(11585, 0, -11585, 0, 131072, 65536, 0);      // quarter turn about -y
        queue_pose(0, 16384, 0, 0, 65536, 65536, 65536);        // half turn about x
        queue_pose(-16384, 0, 0, 0, 123456, -654321, 7);
        queue_pose(32767, 32767, 32767, 32767, CMAX, CMAX, CMAX);
        queue_pose(-32768, -32768, -32768, -32768, CMIN, CMIN, CMIN);
        queue_pose(-32768, 0, 0, 0, 65536, -65536, 1);          // diagonal saturates
        queue_pose(32767, -32768, 32767, -32768, CMAX, CMIN, CMAX);
        queue_pose(16384, 0, 0, 0, CMAX, CMAX, CMAX);
        queue_pose(16384, 0, 0, 0, CMIN, CMIN, CMIN);
        queue_pose(0, 0, 0, 16384, CMAX, CMIN, 0);              // translation saturates
        queue_pose(0, 0, 0, 16384, CMIN, CMAX, CMIN);
        queue_pose(0, 64, 64, 0, 0, 0, 0);                      // rounding tie upward
        queue_pose(0, 64, -64, 0, 0, 0, 0);                     // negative tie
        queue_pose(1, -1, 1, -1, -1, 1, -1);
        queue_pose(5000, -3000, 12000, 700, 0, 0, 0);           // non-unit, zero centre
        queue_pose(-20000, 25000, -18000, 30000, 3 << 16, -(5 << 16), 1 << 16);
        queue_pose(16384, 0, 0, 0, 0, 0, 0);

        // sender waits here until every matrix is back
        wait (pose_queue.size() == 0 && !in_valid && matrix_due.size() == 0);

        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            for (k = 0; k < CHUNK_LEN; k++) begin
                if ($urandom_range(0, 9) < 6) begin
                    // near-unit quaternion from a random direction
                    a = real'(int'($urandom_range(0, 20000))) - 10000.0;
                    b = real'(int'($urandom_range(0, 20000))) - 10000.0;
                    c = real'(int'($urandom_range(0, 20000))) - 10000.0;
                    d = real'(int'($urandom_range(0, 20000))) - 10000.0;
                    norm = $sqrt(a * a + b * b + c * c + d * d);
                    if (norm < 1.0) begin
                        a = 1.0;
                        norm = 1.0;
                    end
                    queue_pose($rtoi(a / norm * 16384.0), $rtoi(b / norm * 16384.0),
                               $rtoi(c / norm * 16384.0), $rtoi(d / norm * 16384.0),
                               random_coord(), random_coord(), random_coord());
                end else begin
                    queue_pose(random_q14(), random_q14(), random_q14(), random_q14(),
                               random_coord(), random_coord(), random_coord());
                end
            end
            wait (pose_queue.size() == 0 && !in_valid && matrix_due.size() == 0);
        end

        repeat (12) @(posedge clk);
        $display("%0d poses sent, %0d matrices checked field by field",
                 items_sent, results_seen);
        $display("input held back for %0d cycles, %0d long output hold-off(s)",
                 held_cycles, long_holds);
        if (fail_count == 0)
            $display("quaternion_to_rotation_matrix: match");
        else
            $display("quaternion_to_rotation_matrix: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/qrm_pkg.sv
src/qrm_rot.sv
src/qrm_trans.sv
src/quaternion_to_rotation_matrix.sv
tb/tb_top.sv
